@@ hdl/sse_pkg.sv @@
// shared types and constants for the sorted set engine
// holds the operation codes, result status codes and the token that walks the cell row
// no dependencies
package sse_pkg;

    // default table size
    localparam int CAPACITY = 1024;

    // field widths
    localparam int KEY_W    = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_MEMBER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // operation carried down the row; probe is an insert on a full table
    typedef enum logic [2:0] {
        OP_MEMBER = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_NOP    = 3'd3,
        OP_PROBE  = 3'd4
    } op_t;

    // one operation in flight through the row
    typedef struct packed {
        logic             vld;
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] carry;
        logic             carry_occ;
        logic             active;
        logic             hit;
    } token_t;

endpackage

@@ hdl/sse_cell.sv @@
// one cell of the sorted row: holds one entry and its occupied flag
// compares, swaps or shifts as a token passes and registers the token for the next cell
// depends on sse_pkg
module sse_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  sse_pkg::token_t          tok_in,
    input  logic [sse_pkg::KEY_W-1:0] next_val,
    input  logic                     next_occ,
    output sse_pkg::token_t          tok_out,
    output logic [sse_pkg::KEY_W-1:0] val,
    output logic                     occ
);

    logic [sse_pkg::KEY_W-1:0] val_reg;
    logic [sse_pkg::KEY_W-1:0] val_next;
    logic                      occ_reg;
    logic                      occ_next;
    sse_pkg::token_t           tok_reg;
    sse_pkg::token_t           tok_next;
    logic                      match;

    assign match = occ_reg && (val_reg == tok_in.key);

    // per-cell step of the passing operation
    always_comb
    begin
        tok_next = tok_in;
        val_next = val_reg;
        occ_next = occ_reg;
        if (tok_in.vld)
        begin
            case (tok_in.op) inside
                sse_pkg::OP_MEMBER, sse_pkg::OP_PROBE:
                begin
                    if (match)
                    begin
                        tok_next.hit = 1'b1;
                    end
                end
                sse_pkg::OP_INSERT:
                begin
                    if (tok_in.active)
                    begin
                        // ripple the displaced entry one place up
                        val_next           = tok_in.carry;
                        occ_next           = tok_in.carry_occ;
                        tok_next.carry     = val_reg;
                        tok_next.carry_occ = occ_reg;
                    end
                    else if (match)
                    begin
                        tok_next.hit = 1'b1;
                    end
                    else if (!tok_in.hit && (!occ_reg || (tok_in.key < val_reg)))
                    begin
                        // sorted position found: place key, carry old entry on
                        tok_next.active    = 1'b1;
                        val_next           = tok_in.key;
                        occ_next           = 1'b1;
                        tok_next.carry     = val_reg;
                        tok_next.carry_occ = occ_reg;
                    end
                end
                sse_pkg::OP_DELETE:
                begin
                    if (tok_in.active || match)
                    begin
                        // pull the next entry down one place
                        tok_next.active = 1'b1;
                        tok_next.hit    = 1'b1;
                        val_next        = next_val;
                        occ_next        = next_occ;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // entry payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
        end
    end

    // occupied flag and token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            tok_reg <= '0;
        end
        else if (en)
        begin
            occ_reg <= occ_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign val     = val_reg;
    assign occ     = occ_reg;

endmodule

@@ hdl/sse_chain.sv @@
// row of sse_cell instances, entry 0 holds the smallest value
// each cell hands its token to the next and lends its entry to the previous one
// depends on sse_pkg, sse_cell
module sse_chain #(
    parameter int CAPACITY = sse_pkg::CAPACITY
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  sse_pkg::token_t tok_in,
    output sse_pkg::token_t tok_out
);

    sse_pkg::token_t           tok [CAPACITY+1];
    logic [sse_pkg::KEY_W-1:0] val [CAPACITY];
    logic                      occ [CAPACITY];

    assign tok[0]  = tok_in;
    assign tok_out = tok[CAPACITY];

    // cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [sse_pkg::KEY_W-1:0] nv;
        logic                      no;

        // the top cell pulls in an empty entry on delete
        if (i == CAPACITY - 1)
        begin : g_top
            assign nv = '0;
            assign no = 1'b0;
        end
        else
        begin : g_mid
            assign nv = val[i+1];
            assign no = occ[i+1];
        end

        sse_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .tok_in   (tok[i]),
            .next_val (nv),
            .next_occ (no),
            .tok_out  (tok[i+1]),
            .val      (val[i]),
            .occ      (occ[i])
        );
    end

endmodule

@@ hdl/sorted_set_engine.sv @@
// sorted set engine top level: issue control, row of cells, result stage and counts
// keeps distinct 16-bit values in ascending order; member test, insert and delete
// depends on sse_pkg, sse_chain
//
// channel   dir  tvalid/tready        payload
// s_*       in   s_tvalid, s_tready   s_tuser[1:0] kind, s_tdata[15:0] key_value
// m_*       out  m_tvalid, m_tready   m_tdata[1:0] status, m_tdata[12:2] entry_count
//
// each transaction walks the cell row one cell per cycle while the row is enabled;
// results leave in order
// accepted transactions are spaced by a gap flag, set by the neighbor read of the delete shift
// an insert that could overflow the table waits until the row is empty
// a blocked result freezes the whole row; reset empties the table at once
module sorted_set_engine #(
    parameter int CAPACITY = sse_pkg::CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] key_value, [23:16] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [12:2] entry_count, [15:13] zero
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int FLT_W = CNT_W + 1;
    localparam int SUM_W = FLT_W + 1;

    sse_pkg::token_t                tok0_reg;
    sse_pkg::token_t                tok0_next;
    sse_pkg::token_t                tail;
    logic                           gap_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [FLT_W-1:0]               inflight_reg;
    logic [FLT_W-1:0]               pend_reg;
    logic                           m_tvalid_reg;
    logic [sse_pkg::STATUS_W-1:0]   status_reg;
    logic [sse_pkg::STATUS_W-1:0]   status_next;
    logic [sse_pkg::COUNT_W-1:0]    ecount_reg;
    logic                           en;
    logic                           room;
    logic                           ins_ok;
    logic                           accept;
    logic                           fire;
    sse_pkg::op_t                   issue_op;

    // row moves unless a result is blocked at the output
    assign en = !(tail.vld && m_tvalid_reg && !m_tready);

    // insert is safe when committed count plus pending inserts leaves room
    assign room   = (SUM_W'(count_reg) + SUM_W'(pend_reg)) < SUM_W'(CAPACITY);
    assign ins_ok = room || (inflight_reg == '0);

    assign s_tready = en && !gap_reg && ((s_tuser != sse_pkg::KIND_INSERT) || ins_ok);
    assign accept   = s_tvalid && s_tready;
    assign fire     = en && tail.vld;

    // kind decode into row operation
    always_comb
    begin
        unique case (s_tuser)
            sse_pkg::KIND_MEMBER: issue_op = sse_pkg::OP_MEMBER;
            sse_pkg::KIND_INSERT: issue_op = room ? sse_pkg::OP_INSERT : sse_pkg::OP_PROBE;
            sse_pkg::KIND_DELETE: issue_op = sse_pkg::OP_DELETE;
            default:              issue_op = sse_pkg::OP_NOP;
        endcase
    end

    // new token for the first cell
    always_comb
    begin
        tok0_next           = '0;
        tok0_next.vld       = accept;
        tok0_next.op        = issue_op;
        tok0_next.key       = s_tdata[sse_pkg::KEY_W-1:0];
        tok0_next.carry     = s_tdata[sse_pkg::KEY_W-1:0];
        tok0_next.carry_occ = 1'b0;
    end

    sse_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tok_in  (tok0_reg),
        .tok_out (tail)
    );

    // status and count of the transaction leaving the row
    always_comb
    begin
        status_next = sse_pkg::ST_NOT_DONE;
        count_next  = count_reg;
        case (tail.op)
            sse_pkg::OP_MEMBER:
            begin
                status_next = tail.hit ? sse_pkg::ST_OK : sse_pkg::ST_NOT_DONE;
            end
            sse_pkg::OP_INSERT:
            begin
                if (!tail.hit)
                begin
                    status_next = sse_pkg::ST_OK;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            sse_pkg::OP_DELETE:
            begin
                if (tail.hit)
                begin
                    status_next = sse_pkg::ST_OK;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            sse_pkg::OP_PROBE:
            begin
                status_next = tail.hit ? sse_pkg::ST_NOT_DONE : sse_pkg::ST_FULL;
            end
            default:
            begin
                status_next = sse_pkg::ST_NOT_DONE;
            end
        endcase
    end

    // issue stage and spacing flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
            gap_reg  <= 1'b0;
        end
        else if (en)
        begin
            tok0_reg <= tok0_next;
            gap_reg  <= accept;
        end
    end

    // committed count and in-flight bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            inflight_reg <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            if (fire)
            begin
                count_reg <= count_next;
            end
            inflight_reg <= inflight_reg + FLT_W'(accept) - FLT_W'(fire);
            pend_reg     <= pend_reg
                            + FLT_W'(accept && (issue_op == sse_pkg::OP_INSERT))
                            - FLT_W'(fire && (tail.op == sse_pkg::OP_INSERT));
        end
    end

    // result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            ecount_reg <= sse_pkg::COUNT_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, ecount_reg, status_reg};

endmodule
